// ===== sv/wpm_pkg.sv =====
// Package for the wildcard pattern matcher: the operation codes, the wildcard symbols
// and the per-item control bundle. It depends on nothing else.
package wpm_pkg;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_e;

  localparam logic [7:0] SYM_STAR = 8'd42;
  localparam logic [7:0] SYM_ANY  = 8'd63;

  // Control for the item being processed in the current cycle.
  typedef struct packed {
    logic       pat_wr;
    logic       txt_en;
    logic       last;
    logic [7:0] symbol;
  } step_t;

endpackage

// ===== sv/wpm_pat_store.sv =====
// Pattern storage for the wildcard pattern matcher: the bytes, the length, the open or closed
// state and the overflow flag. It depends on wpm_pkg.
module wpm_pat_store import wpm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 16,
  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1),
  localparam int unsigned IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  step_t                         step_i,
  output logic [PATTERN_MAX-1:0][7:0]   pat_o,
  output logic [LenW-1:0]               len_o,
  output logic                          ovf_o,
  output logic                          fresh_o
);

  logic [PATTERN_MAX-1:0][7:0] store_q;
  logic [LenW-1:0]             len_q, len_d, base_len;
  logic                        closed_q, closed_d;
  logic                        ovf_q, ovf_d;
  logic                        room;

  // A pattern byte that arrives after a closed pattern starts a new one.
  assign fresh_o  = step_i.pat_wr & closed_q;
  assign base_len = closed_q ? '0 : len_q;
  assign room     = base_len < LenW'(PATTERN_MAX);

  always_comb begin
    len_d    = len_q;
    ovf_d    = ovf_q;
    closed_d = closed_q;
    if (step_i.pat_wr) begin
      ovf_d = closed_q ? 1'b0 : ovf_q;
      if (room) begin
        len_d = base_len + LenW'(1);
      end else begin
        len_d = base_len;
        ovf_d = 1'b1;
      end
      closed_d = step_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ovf_q    <= 1'b0;
      closed_q <= 1'b1;
    end else begin
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      closed_q <= closed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.pat_wr && room) begin
      store_q[base_len[IdxW-1:0]] <= step_i.symbol;
    end
  end

  assign pat_o = store_q;
  assign len_o = len_q;
  assign ovf_o = ovf_q;

endmodule

// ===== sv/wpm_vec_unit.sv =====
// Prefix-match vector of the wildcard pattern matcher and its update per text byte.
// It depends on wpm_pkg.
module wpm_vec_unit import wpm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 16,
  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  step_t                         step_i,
  input  logic                          fresh_i,
  input  logic [PATTERN_MAX-1:0][7:0]   pat_i,
  input  logic [LenW-1:0]               len_i,
  output logic                          match_o,
  output logic [PATTERN_MAX:0]          vec_o
);

  localparam int unsigned Steps = LenW;
  localparam logic [PATTERN_MAX:0] VecInit = (PATTERN_MAX + 1)'(1);

  logic [PATTERN_MAX:0] vec_q, vec_d;
  logic [PATTERN_MAX:0] star_prp, closed, gen, nxt;

  // Sets bit k when gen[k] is set or a set bit runs up to k through propagate bits.
  // Log-depth prefix network, so the run through a string of stars stays shallow.
  function automatic logic [PATTERN_MAX:0] run_fill(input logic [PATTERN_MAX:0] g_in,
                                                    input logic [PATTERN_MAX:0] p_in);
    logic [PATTERN_MAX:0] g, p, gn, pn;
    g = g_in;
    p = p_in;
    for (int s = 0; s < Steps; s++) begin
      gn = g;
      pn = p;
      for (int k = 0; k <= PATTERN_MAX; k++) begin
        if (k >= (1 << s)) begin
          gn[k] = g[k] | (p[k] & g[k - (1 << s)]);
          pn[k] = p[k] & p[k - (1 << s)];
        end
      end
      g = gn;
      p = pn;
    end
    return g;
  endfunction

  always_comb begin
    star_prp    = '0;
    gen         = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      star_prp[k+1] = (LenW'(k) < len_i) && (pat_i[k] == SYM_STAR);
    end
    // A set bit followed by stars also covers the prefixes that end in those stars.
    closed = run_fill(vec_q, star_prp);
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (LenW'(k) < len_i) begin
        if (pat_i[k] == SYM_STAR) begin
          gen[k+1] = closed[k+1];
        end else begin
          gen[k+1] = closed[k] && ((pat_i[k] == SYM_ANY) || (pat_i[k] == step_i.symbol));
        end
      end
    end
    // A star also absorbs the current byte behind any matching shorter prefix.
    nxt = run_fill(gen, star_prp);
  end

  assign match_o = nxt[len_i];

  always_comb begin
    vec_d = vec_q;
    if (fresh_i || (step_i.txt_en && step_i.last)) begin
      vec_d = VecInit;
    end else if (step_i.txt_en) begin
      vec_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= VecInit;
    end else begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

// ===== sv/wildcard_pattern_matcher.sv =====
// Top level of the wildcard pattern matcher: input register, pattern store, vector unit
// and result register. It depends on wpm_pkg, wpm_pat_store and wpm_vec_unit.
//
// Usage: one input channel (in_valid_i / in_stall_o) carries items of operation, symbol
// and last. Pattern items (operation 0) are loaded first, the one with last set closes
// the pattern; '*' matches any run of bytes and '?' any single byte. Text items
// (operation 1) are then streamed. A text item with last set gives one result item on
// the output channel (out_valid_o / out_stall_i): matched and pattern_overflow. A
// pattern byte beyond PATTERN_MAX sets the overflow flag and is dropped.
// Timing: an accepted item is held in the input register, where the prefix-match vector
// is updated, and its result is then captured in the result register. One item is
// accepted every cycle while in_stall_o is low; the limit is the combinational vector
// update through two log-depth star-propagation networks over PATTERN_MAX + 1 bits.
// Stall: the result register holds while out_stall_i is high. Items that give no result
// keep flowing; an item that ends a text waits in the input register, and in_stall_o
// rises, only while the previous result is still held.
// Reset: clears both registers' valid bits, the pattern length and overflow flag, marks
// the pattern closed and sets the vector to match only the empty prefix. Pattern bytes
// are undefined until loaded.
module wildcard_pattern_matcher import wpm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] symbol_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       pattern_overflow_o
);

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);

  // Input register.
  logic       in_vld_q;
  op_e        op_q;
  logic [7:0] sym_q;
  logic       last_q;

  // Result register.
  logic       out_vld_q;
  logic       matched_q;
  logic       ovf_out_q;

  logic       accept;
  logic       gives_result;
  logic       proc;
  step_t      step;

  logic [PATTERN_MAX-1:0][7:0] pat;
  logic [LenW-1:0]             len;
  logic                        ovf;
  logic                        fresh;
  logic                        match;
  logic [PATTERN_MAX:0]        vec;

  // The held item is processed unless it ends a text while the previous result is stuck.
  assign gives_result = (op_q == OP_TEXT) && last_q;
  assign proc         = in_vld_q && !(gives_result && out_vld_q && out_stall_i);
  assign in_stall_o   = in_vld_q && !proc;
  assign accept       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(operation_i);
      sym_q  <= symbol_i;
      last_q <= last_i;
    end
  end

  always_comb begin
    step.pat_wr = proc && (op_q == OP_PATTERN);
    step.txt_en = proc && (op_q == OP_TEXT);
    step.last   = last_q;
    step.symbol = sym_q;
  end

  wpm_pat_store #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .pat_o  (pat),
    .len_o  (len),
    .ovf_o  (ovf),
    .fresh_o(fresh)
  );

  wpm_vec_unit #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_vec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .fresh_i(fresh),
    .pat_i  (pat),
    .len_i  (len),
    .match_o(match),
    .vec_o  (vec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc && gives_result) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && gives_result) begin
      matched_q <= match;
      ovf_out_q <= ovf;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = ovf_out_q;

  // The input side only backs up behind a result that is being held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_vld_q && out_stall_i))
    else $error("input stalled without a held result");

  // The stored length never passes the capacity.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len <= LenW'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  // Overflow can only be flagged once the store is full.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf |-> (len == LenW'(PATTERN_MAX)))
    else $error("overflow flagged with room left");

  // The end of a text leaves the vector matching the empty prefix only.
  a_vec_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && gives_result) |=> (vec == (PATTERN_MAX + 1)'(1)))
    else $error("vector not cleared after end of text");

endmodule
